[src/stq_pkg.sv]
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer queue
// Command and result codes, payload structs and the front-to-back token.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int MAX_FIRE = 32;
  localparam logic [31:0] NONE_DEADLINE = 32'hffffffff;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_ALLOC   = 3'd1,
    CMD_FREE    = 3'd2,
    CMD_INIT    = 3'd3,
    CMD_SETTIME = 3'd4
  } cmd_t;

  localparam logic [2:0] KIND_DONE       = 3'd0;
  localparam logic [2:0] KIND_FIRED      = 3'd1;
  localparam logic [2:0] KIND_ALLOC_OK   = 3'd2;
  localparam logic [2:0] KIND_ALLOC_FAIL = 3'd3;
  localparam logic [2:0] KIND_FULL       = 3'd4;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  slot;
    logic [3:0]  queue_id;
    logic [7:0]  payload;
    logic [31:0] timeout;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] slot_out;
    logic [3:0] fired_queue;
    logic [7:0] fired_data;
    logic       last;
  } out_item_t;

  // Work handed from the front end to the list engine
  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_TICK   = 2'd1,
    OP_INSERT = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [2:0]       kind;
    logic [SLOT_W-1:0] slot;
    logic [31:0]      deadline;
  } token_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_FIRE_RD, BK_FIRE_CHK, BK_FIRE_OUT, BK_SHIFT, BK_INS_RD, BK_INS_CHK,
    BK_INS_MOVE
  } bk_state_t;

endpackage

[src/stq_front.sv]
// ----------------------------------------------------------------------------
// stq_front: command decode and slot table
// Owns slot states, queue ids, data bytes and the tick count; turns each
// transaction into one token for the list engine.
// ----------------------------------------------------------------------------
module stq_front import stq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     tok_valid,
  input  logic     tok_stall,
  output token_t   tok,
  input  logic     eng_busy,
  // slot table reads and state updates from the back end
  input  logic [SLOT_W-1:0] rd_slot,
  output logic [3:0] rd_queue,
  output logic [7:0] rd_data,
  input  logic       set_alloc,
  input  logic [SLOT_W-1:0] set_alloc_slot,
  input  logic       set_run,
  input  logic [SLOT_W-1:0] set_run_slot
);

  logic [1:0]  slot_state [NUM_SLOTS];
  logic [3:0]  slot_queue [NUM_SLOTS];
  logic [7:0]  slot_data [NUM_SLOTS];
  logic [31:0] tick_count;
  logic        slot_ok;
  logic        found;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] s;
  logic        take;
  token_t      tok_next;

  assign s = in_data.slot[SLOT_W-1:0];
  assign slot_ok = (32'(in_data.slot) < NUM_SLOTS);
  // Hold new transactions until the list engine has finished the previous one
  assign in_stall = tok_valid || eng_busy;
  assign take = in_valid && !in_stall;

  always_comb begin
    found = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (slot_state[i] == ST_FREE) begin
        found = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    tok_next = '{op: OP_REPORT, kind: KIND_DONE, slot: '0,
                 deadline: in_data.timeout + tick_count};
    case (in_data.command)
      CMD_TICK: begin
        tok_next.op = OP_TICK;
        tok_next.deadline = tick_count + 32'd1;
      end
      CMD_ALLOC: begin
        tok_next.kind = found ? KIND_ALLOC_OK : KIND_ALLOC_FAIL;
        tok_next.slot = found ? free_idx : '0;
      end
      CMD_SETTIME: begin
        tok_next.slot = s;
        if (slot_ok) tok_next.op = OP_INSERT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      tick_count <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) slot_state[i] <= ST_FREE;
    end else begin
      if (take) begin
        tok_valid <= 1'b1;
        tok <= tok_next;
      end else if (!tok_stall) begin
        tok_valid <= 1'b0;
      end
      if (set_alloc) slot_state[set_alloc_slot] <= ST_ALLOC;
      else if (set_run) slot_state[set_run_slot] <= ST_RUN;
      if (take) begin
        case (in_data.command)
          CMD_TICK: tick_count <= tick_count + 32'd1;
          CMD_ALLOC: if (found) slot_state[free_idx] <= ST_ALLOC;
          CMD_FREE: if (slot_ok) slot_state[s] <= ST_FREE;
          CMD_INIT: if (slot_ok) begin
            slot_queue[s] <= in_data.queue_id;
            slot_data[s] <= in_data.payload;
          end
          default: ;
        endcase
      end
    end
  end

  assign rd_queue = slot_queue[rd_slot];
  assign rd_data  = slot_data[rd_slot];

endmodule

[src/stq_back.sv]
// ----------------------------------------------------------------------------
// stq_back: sorted deadline list engine
// Walks the order list entry by entry to fire expired timers or to
// insert a new one, and emits the results; it takes no new token until idle.
// ----------------------------------------------------------------------------
module stq_back import stq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      tok_valid,
  output logic      tok_stall,
  input  token_t    tok,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  output logic      eng_busy,
  output logic [SLOT_W-1:0] rd_slot,
  input  logic [3:0] rd_queue,
  input  logic [7:0] rd_data,
  output logic       set_alloc,
  output logic [SLOT_W-1:0] set_alloc_slot,
  output logic       set_run,
  output logic [SLOT_W-1:0] set_run_slot
);

  logic [SLOT_W-1:0] order_list [NUM_SLOTS];
  logic [31:0] slot_deadline [NUM_SLOTS];
  logic [CNT_W-1:0] active_count;
  logic [31:0] next_deadline;
  bk_state_t state, state_next;
  token_t cur;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] nfired;
  logic [SLOT_W-1:0] ent;
  logic [31:0] ent_dl;
  out_item_t pend;
  logic out_free;
  logic idle_take;
  logic fire_go;
  logic emit;

  assign out_free = !out_valid || !out_stall;
  assign tok_stall = (state != BK_IDLE) || !out_free;
  assign eng_busy = (state != BK_IDLE);
  assign idle_take = (state == BK_IDLE) && tok_valid && out_free;
  assign fire_go = (tok.op == OP_TICK) && (next_deadline <= tok.deadline);
  assign rd_slot = ent;
  assign set_alloc = (state == BK_FIRE_OUT) && out_free;
  assign set_alloc_slot = ent;
  assign set_run = idle_take && (tok.op == OP_INSERT) &&
                   (active_count != CNT_W'(NUM_SLOTS));
  assign set_run_slot = tok.slot;
  // A fired result is held back one step so the final one can carry last
  assign emit = (idle_take && !fire_go) ||
                ((state == BK_FIRE_OUT) && out_free && (nfired != '0)) ||
                ((state == BK_SHIFT) && (idx >= active_count - nfired) && out_free);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (idle_take) begin
        if (fire_go) state_next = BK_FIRE_RD;
        else if (tok.op == OP_INSERT && active_count != CNT_W'(NUM_SLOTS))
          state_next = BK_INS_RD;
      end
      BK_FIRE_RD: begin
        if (idx < active_count && 32'(idx) < MAX_FIRE) state_next = BK_FIRE_CHK;
        else state_next = BK_SHIFT;
      end
      BK_FIRE_CHK: state_next = (ent_dl > cur.deadline) ? BK_SHIFT : BK_FIRE_OUT;
      BK_FIRE_OUT: if (out_free) state_next = BK_FIRE_RD;
      BK_SHIFT: if (idx >= active_count - nfired && out_free) state_next = BK_IDLE;
      BK_INS_RD: state_next = (idx < active_count) ? BK_INS_CHK : BK_INS_MOVE;
      BK_INS_CHK: state_next = (ent_dl >= cur.deadline) ? BK_INS_MOVE : BK_INS_RD;
      BK_INS_MOVE: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      out_valid <= 1'b0;
      active_count <= '0;
      next_deadline <= NONE_DEADLINE;
    end else begin
      state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        BK_IDLE: if (idle_take) begin
          cur <= tok; idx <= '0; nfired <= '0;
          if (!fire_go) begin
            out_data <= '{kind: (tok.op == OP_TICK) ? KIND_DONE :
                          (tok.op == OP_INSERT) ?
                          ((active_count == CNT_W'(NUM_SLOTS)) ? KIND_FULL : KIND_DONE)
                          : tok.kind,
                          slot_out: (tok.op == OP_REPORT) ? 5'(tok.slot) : 5'd0,
                          fired_queue: '0, fired_data: '0, last: 1'b1};
            if (tok.op == OP_INSERT && active_count != CNT_W'(NUM_SLOTS))
              slot_deadline[tok.slot] <= tok.deadline;
          end
        end
        BK_FIRE_RD: begin
          ent <= order_list[idx[SLOT_W-1:0]];
          ent_dl <= slot_deadline[order_list[idx[SLOT_W-1:0]]];
          // Restart the index for the compaction pass
          if (state_next == BK_SHIFT) idx <= '0;
        end
        BK_FIRE_CHK: if (state_next == BK_SHIFT) idx <= '0;
        BK_FIRE_OUT: if (out_free) begin
          if (nfired != '0) out_data <= pend;
          pend <= '{kind: KIND_FIRED, slot_out: 5'(ent), fired_queue: rd_queue,
                    fired_data: rd_data, last: 1'b0};
          idx <= idx + 1'b1;
          nfired <= nfired + 1'b1;
        end
        BK_SHIFT: begin
          if (idx < active_count - nfired) begin
            order_list[idx[SLOT_W-1:0]] <= order_list[SLOT_W'(idx + nfired)];
            idx <= idx + 1'b1;
          end else if (out_free) begin
            active_count <= active_count - nfired;
            next_deadline <= (active_count != nfired) ? slot_deadline[order_list[0]]
                                                     : NONE_DEADLINE;
            if (nfired == '0) begin
              out_data <= '{kind: KIND_DONE, slot_out: '0, fired_queue: '0,
                            fired_data: '0, last: 1'b1};
            end else begin
              out_data <= '{kind: pend.kind, slot_out: pend.slot_out,
                            fired_queue: pend.fired_queue,
                            fired_data: pend.fired_data, last: 1'b1};
            end
          end
        end
        BK_INS_RD: if (idx < active_count) begin
          ent_dl <= slot_deadline[order_list[idx[SLOT_W-1:0]]];
        end
        BK_INS_CHK: if (ent_dl < cur.deadline) idx <= idx + 1'b1;
        BK_INS_MOVE: begin
          for (int j = NUM_SLOTS - 1; j > 0; j--)
            if (CNT_W'(j) > idx && CNT_W'(j) <= active_count)
              order_list[j] <= order_list[j-1];
          order_list[idx[SLOT_W-1:0]] <= cur.slot;
          active_count <= active_count + 1'b1;
          next_deadline <= (idx == '0) ? cur.deadline : slot_deadline[order_list[0]];
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) active_count <= CNT_W'(NUM_SLOTS))
    else $error("list overflow");
  assert property (@(posedge clk) disable iff (rst)
    (state != BK_IDLE) |-> tok_stall) else $error("token taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    (active_count == '0 && state == BK_IDLE) |-> next_deadline == NONE_DEADLINE)
    else $error("empty list with live deadline");

endmodule

[src/sorted_software_timer_queue_unit.sv]
// Every transaction but a firing tick gives its one result as the list engine takes its
// token; alloc, free, init, a tick with nothing due and a refused set time end there.
// Set time then walks the list entry by entry to the insert point and moves the entries.
// A firing tick reads, checks and emits each fired timer, then compacts the remaining entries.
// A new transaction is taken once the list engine is idle; one more waits behind a stall.
// Reset (synchronous, rst high) frees all slots, empties the list, zeroes the count.
module sorted_software_timer_queue_unit import stq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic tok_valid, tok_stall;
  token_t tok;
  logic eng_busy;
  logic [SLOT_W-1:0] rd_slot, set_alloc_slot, set_run_slot;
  logic [3:0] rd_queue;
  logic [7:0] rd_data;
  logic set_alloc, set_run;

  stq_front u_front (.clk, .rst, .in_valid, .in_stall, .in_data, .tok_valid,
    .tok_stall, .tok, .eng_busy, .rd_slot, .rd_queue, .rd_data, .set_alloc,
    .set_alloc_slot, .set_run, .set_run_slot);

  stq_back u_back (.clk, .rst, .tok_valid, .tok_stall, .tok, .out_valid,
    .out_stall, .out_data, .eng_busy, .rd_slot, .rd_queue, .rd_data, .set_alloc,
    .set_alloc_slot, .set_run, .set_run_slot);

endmodule

[bench/sorted_software_timer_queue_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue testbench
// Drives random and directed command transactions into the timer queue and
// checks every result against a behavioral model of the slot pool and list.
// ----------------------------------------------------------------------------
module sorted_software_timer_queue_unit_tb;
  import stq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  sorted_software_timer_queue_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Timer pool model
  logic [1:0]  mdl_state[NUM_SLOTS];
  logic [3:0]  mdl_queue[NUM_SLOTS];
  logic [7:0]  mdl_data[NUM_SLOTS];
  logic [31:0] mdl_deadline[NUM_SLOTS];
  logic [4:0]  mdl_order[NUM_SLOTS];
  int unsigned mdl_active;
  logic [31:0] mdl_ticks;
  logic [31:0] mdl_next;
  // Generator-side shadow of the pool, used to keep stimulus legal
  bit          gen_inited[NUM_SLOTS];

  in_item_t    pending_cmds[$];
  out_item_t   expected_results[$];
  int          error_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          recv_hold;
  int          hold_cycles;
  int          quiet_cycles;
  bit          gen_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t mk_res(logic [2:0] k, logic [4:0] s, logic [3:0] q,
                                       logic [7:0] d, logic l);
    out_item_t r;
    r.kind = k; r.slot_out = s; r.fired_queue = q; r.fired_data = d; r.last = l;
    return r;
  endfunction

  task automatic predict_timer_queue(input in_item_t it);
    int n;
    int i;
    int pos;
    logic [31:0] dl;
    bit found;
    case (it.command)
      CMD_TICK: begin
        mdl_ticks = mdl_ticks + 32'd1;
        n = 0;
        if (mdl_next <= mdl_ticks) begin
          while (n < mdl_active && n < MAX_FIRE &&
                 mdl_deadline[mdl_order[n]] <= mdl_ticks) begin
            mdl_state[mdl_order[n]] = ST_ALLOC;
            expected_results.push_back(mk_res(KIND_FIRED, mdl_order[n],
              mdl_queue[mdl_order[n]], mdl_data[mdl_order[n]], 1'b0));
            n++;
          end
          mdl_active -= n;
          for (i = 0; i < mdl_active; i++) mdl_order[i] = mdl_order[i + n];
          mdl_next = (mdl_active > 0) ? mdl_deadline[mdl_order[0]] : NONE_DEADLINE;
        end
        if (n == 0) expected_results.push_back(mk_res(KIND_DONE, 0, 0, 0, 1'b1));
        else expected_results[$].last = 1'b1;
      end
      CMD_ALLOC: begin
        found = 0;
        for (i = 0; i < NUM_SLOTS && !found; i++) begin
          if (mdl_state[i] == ST_FREE) begin
            mdl_state[i] = ST_ALLOC;
            expected_results.push_back(mk_res(KIND_ALLOC_OK, 5'(i), 0, 0, 1'b1));
            found = 1;
          end
        end
        if (!found) expected_results.push_back(mk_res(KIND_ALLOC_FAIL, 0, 0, 0, 1'b1));
      end
      CMD_FREE: begin
        mdl_state[it.slot] = ST_FREE;
        expected_results.push_back(mk_res(KIND_DONE, 0, 0, 0, 1'b1));
      end
      CMD_INIT: begin
        mdl_queue[it.slot] = it.queue_id;
        mdl_data[it.slot] = it.payload;
        expected_results.push_back(mk_res(KIND_DONE, 0, 0, 0, 1'b1));
      end
      CMD_SETTIME: begin
        if (mdl_active >= NUM_SLOTS) begin
          expected_results.push_back(mk_res(KIND_FULL, 0, 0, 0, 1'b1));
        end else begin
          dl = it.timeout + mdl_ticks;
          mdl_deadline[it.slot] = dl;
          mdl_state[it.slot] = ST_RUN;
          pos = mdl_active;
          for (i = mdl_active - 1; i >= 0; i--)
            if (mdl_deadline[mdl_order[i]] >= dl) pos = i;
          for (i = mdl_active; i > pos; i--) mdl_order[i] = mdl_order[i - 1];
          mdl_order[pos] = it.slot;
          mdl_active++;
          mdl_next = mdl_deadline[mdl_order[0]];
          expected_results.push_back(mk_res(KIND_DONE, 0, 0, 0, 1'b1));
        end
      end
      default: expected_results.push_back(mk_res(KIND_DONE, 0, 0, 0, 1'b1));
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Generator helpers; the shadow tracks which slots may appear in the list
  function automatic in_item_t mk_cmd(logic [2:0] c, logic [4:0] s, logic [3:0] q,
                                      logic [7:0] p, logic [31:0] t);
    in_item_t it;
    it.command = c; it.slot = s; it.queue_id = q; it.payload = p; it.timeout = t;
    return it;
  endfunction

  task automatic add_cmd(input in_item_t it);
    if (it.command == CMD_INIT) gen_inited[it.slot] = 1;
    pending_cmds.push_back(it);
  endtask

  function automatic logic [4:0] pick_inited();
    logic [4:0] s;
    do s = 5'($urandom_range(NUM_SLOTS - 1)); while (!gen_inited[s]);
    return s;
  endfunction

  function automatic logic [31:0] rand_timeout();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return 32'hffffffff - $urandom_range(3);
      2:       return 32'd0;
      default: return $urandom_range(12);
    endcase
  endfunction

  task automatic add_random_cmd();
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6:
        add_cmd(mk_cmd(CMD_TICK, 5'($urandom), 4'($urandom), 8'($urandom), $urandom));
      7: add_cmd(mk_cmd(CMD_ALLOC, 5'($urandom), 4'($urandom), 8'($urandom), $urandom));
      8: add_cmd(mk_cmd(CMD_FREE, 5'($urandom), 4'($urandom), 8'($urandom), $urandom));
      9, 10:
        add_cmd(mk_cmd(CMD_INIT, 5'($urandom), 4'($urandom), 8'($urandom), $urandom));
      11: add_cmd(mk_cmd(3'($urandom_range(7, 5)), 5'($urandom), 4'($urandom),
                         8'($urandom), $urandom));
      default: add_cmd(mk_cmd(CMD_SETTIME, pick_inited(), 4'($urandom), 8'($urandom),
                              rand_timeout()));
    endcase
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    int i;
    rst = 1'b1;
    gen_done = 0;
    error_count = 0;
    recv_hold = 0;
    send_idle_pct = 10;
    recv_idle_pct = 71;
    for (i = 0; i < NUM_SLOTS; i++) gen_inited[i] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // Directed: extremes of every field and command
    add_cmd(mk_cmd(CMD_TICK, 0, 0, 0, 0));
    add_cmd(mk_cmd(CMD_ALLOC, 5'h1f, 4'hf, 8'hff, 32'hffffffff));
    add_cmd(mk_cmd(CMD_INIT, 0, 4'hf, 8'hff, 32'hffffffff));
    add_cmd(mk_cmd(CMD_INIT, 5'h1f, 4'h0, 8'h00, 32'h0));
    add_cmd(mk_cmd(CMD_SETTIME, 0, 0, 0, 32'd0));
    add_cmd(mk_cmd(CMD_SETTIME, 5'h1f, 0, 0, 32'd2));
    add_cmd(mk_cmd(CMD_SETTIME, 0, 0, 0, 32'd2));  // re-arm a listed slot
    add_cmd(mk_cmd(CMD_FREE, 5'h1f, 0, 0, 0));    // free a running slot
    add_cmd(mk_cmd(CMD_TICK, 0, 0, 0, 0));
    add_cmd(mk_cmd(CMD_TICK, 0, 0, 0, 0));
    add_cmd(mk_cmd(CMD_TICK, 0, 0, 0, 0));
    add_cmd(mk_cmd(3'd5, 0, 0, 0, 0));
    add_cmd(mk_cmd(3'd7, 5'h1f, 4'hf, 8'hff, 32'hffffffff));
    add_cmd(mk_cmd(CMD_SETTIME, 0, 0, 0, 32'hffffffff));
    add_cmd(mk_cmd(CMD_SETTIME, 5'h1f, 0, 0, 32'hfffffffa));
    for (i = 0; i < NUM_SLOTS + 1; i++) add_cmd(mk_cmd(CMD_ALLOC, 0, 0, 0, 0));
    wait_drained();
    // Fill the list to capacity, then overflow it
    for (i = 0; i < NUM_SLOTS; i++)
      add_cmd(mk_cmd(CMD_INIT, 5'(i), 4'($urandom), 8'($urandom), 0));
    for (i = 0; i < NUM_SLOTS; i++)
      add_cmd(mk_cmd(CMD_SETTIME, 5'(i), 0, 0, $urandom_range(3)));
    add_cmd(mk_cmd(CMD_SETTIME, 3, 0, 0, 0));
    add_cmd(mk_cmd(CMD_TICK, 0, 0, 0, 0));
    add_cmd(mk_cmd(CMD_TICK, 0, 0, 0, 0));
    add_cmd(mk_cmd(CMD_TICK, 0, 0, 0, 0));
    add_cmd(mk_cmd(CMD_TICK, 0, 0, 0, 0));
    add_cmd(mk_cmd(CMD_TICK, 0, 0, 0, 0));
    add_cmd(mk_cmd(CMD_TICK, 0, 0, 0, 0));
    wait_drained();   // sender pause until all results are back
    // Hold the receiver off while commands keep coming
    recv_hold = 1;
    for (i = 0; i < 60; i++) add_random_cmd();
    @(posedge clk);
    while (hold_cycles < 600) @(posedge clk);
    recv_hold = 0;
    wait_drained();
    for (i = 0; i < 100; i++) add_random_cmd();
    wait_drained();
    send_idle_pct = 71;
    recv_idle_pct = 10;
    for (i = 0; i < 100; i++) add_random_cmd();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (i = 0; i < 100; i++) add_random_cmd();
    wait_drained();
    gen_done = 1;
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) mdl_state[i] = ST_FREE;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        mdl_queue[i] = '0; mdl_data[i] = '0; mdl_deadline[i] = '0; mdl_order[i] = '0;
      end
      mdl_active = 0;
      mdl_ticks = '0;
      mdl_next = NONE_DEADLINE;
    end else begin
      if (in_valid && !in_stall) predict_timer_queue(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_cmds.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
      quiet_cycles = 0;
      hold_cycles = 0;
    end else begin
      // Count the length of the current receiver hold
      if (recv_hold) hold_cycles++;
      else hold_cycles = 0;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_data), 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.kind != want.kind)
            report_mismatch("kind", 32'(out_data.kind), 32'(want.kind));
          if (out_data.slot_out != want.slot_out)
            report_mismatch("slot_out", 32'(out_data.slot_out), 32'(want.slot_out));
          if (out_data.fired_queue != want.fired_queue)
            report_mismatch("fired_queue", 32'(out_data.fired_queue),
                            32'(want.fired_queue));
          if (out_data.fired_data != want.fired_data)
            report_mismatch("fired_data", 32'(out_data.fired_data),
                            32'(want.fired_data));
          if (out_data.last != want.last)
            report_mismatch("last", 32'(out_data.last), 32'(want.last));
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || recv_hold)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT && !gen_done) begin
        $display("status: fail");
        $finish;
      end
      out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

endmodule

[filelist.f]
src/stq_pkg.sv
src/stq_front.sv
src/stq_back.sv
src/sorted_software_timer_queue_unit.sv
bench/sorted_software_timer_queue_unit_tb.sv
